### src/mnr_pkg.sv
// shared types and constants for the midi note remapper
package mnr_pkg;

  localparam int BYTE_W = 8;
  localparam int NOTE_W = 7;
  localparam int CHAN_W = 4;
  localparam int VEL_W  = 7;
  localparam int ACT_W  = 2;

  localparam logic [BYTE_W-1:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;

  // stored map entry payload: channel above note
  localparam int ENTRY_W = CHAN_W + NOTE_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_BYTE  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // map lookup raised by the byte window
  typedef struct packed {
    logic              req;
    logic              is_on;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } lookup_t;

endpackage

### src/midi_note_remapper.sv
// top level of the midi note remapper: window, note map and result path
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  in_     | in  | rx_byte[7:0] map_index[14:8] map_channel[18:15]    | action[1:0]
//          |     | map_note[25:19], zero pad [31:26]                  |
//  out_    | out | channel[3:0] note[10:4] velocity[17:11]            | is_note_on[0]
//          |     | zero pad [23:18]                                   |
//
// one word is taken per cycle while in_tready is high; a result passes through the lookup
// stage, which holds the registered read of the map ram, and then the output register
// in_tready drops only while the lookup stage and the output register both hold a word
// reset clears the window, the fill count and the MAP_ENTRIES map valid flops (128 by default);
// the map ram itself is not cleared, its entries are gated by the valid flops
module midi_note_remapper #(
  parameter int MAP_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rx_byte, map_index, map_channel, map_note
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // channel, note, velocity
  output logic [0:0]  out_tuser   // is_note_on
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  // input unpacking
  logic                        in_acc;
  mnr_pkg::action_t            action;
  logic [mnr_pkg::BYTE_W-1:0]  rx_byte;
  logic [mnr_pkg::NOTE_W-1:0]  map_index;
  logic [mnr_pkg::CHAN_W-1:0]  map_channel;
  logic [mnr_pkg::NOTE_W-1:0]  map_note;

  assign in_acc      = in_tvalid && in_tready;
  assign action      = mnr_pkg::action_t'(in_tuser);
  assign rx_byte     = in_tdata[7:0];
  assign map_index   = in_tdata[14:8];
  assign map_channel = in_tdata[18:15];
  assign map_note    = in_tdata[25:19];

  // decode the accepted word
  logic byte_en, set_en, clr_en;

  always_comb begin
    byte_en = 1'b0;
    set_en  = 1'b0;
    clr_en  = 1'b0;
    case (action)
      mnr_pkg::ACT_BYTE:  byte_en = in_acc;
      mnr_pkg::ACT_SET:   set_en  = in_acc;
      mnr_pkg::ACT_CLEAR: clr_en  = in_acc;
      default: ; // unused action is dropped
    endcase
  end

  // receive window
  mnr_pkg::lookup_t lookup;

  mnr_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (rx_byte),
    .lookup  (lookup)
  );

  // note map: payload in ram, valid flags in flops so reset is immediate
  logic [IDX_W-1:0]            wr_idx, rd_idx;
  logic [mnr_pkg::ENTRY_W-1:0] map_rdata;
  logic [MAP_ENTRIES-1:0]      map_valid_r, map_valid_nxt;

  assign wr_idx = map_index[IDX_W-1:0];
  assign rd_idx = lookup.note[IDX_W-1:0];

  mnr_ram #(
    .WIDTH (mnr_pkg::ENTRY_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map_ram (
    .clk   (clk),
    .we    (set_en),
    .waddr (wr_idx),
    .wdata ({map_channel, map_note}),
    .re    (lookup.req),
    .raddr (rd_idx),
    .rdata (map_rdata)
  );

  always_comb begin
    map_valid_nxt = map_valid_r;
    if (set_en) begin
      map_valid_nxt[wr_idx] = 1'b1;
    end else if (clr_en) begin
      map_valid_nxt[wr_idx] = 1'b0;
    end
  end

  // lookup stage, waits on the ram read; accesses are in word order so no
  // forwarding is needed between a map write and a later read
  logic                       s1_v_r, s1_v_nxt;
  logic                       s1_hit_r, s1_on_r;
  logic [mnr_pkg::VEL_W-1:0]  s1_vel_r;
  logic                       s1_move;

  // output register
  logic                       out_v_r, out_v_nxt;
  logic                       out_on_r;
  logic [mnr_pkg::CHAN_W-1:0] out_chan_r;
  logic [mnr_pkg::NOTE_W-1:0] out_key_r;
  logic [mnr_pkg::VEL_W-1:0]  out_vel_r;

  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !(s1_v_r && out_v_r);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (lookup.req) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = s1_hit_r;  // unmapped notes are dropped here
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      map_valid_r <= map_valid_nxt;
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup.req) begin
      s1_hit_r <= map_valid_r[rd_idx];
      s1_on_r  <= lookup.is_on;
      s1_vel_r <= lookup.velocity;
    end
    if (s1_move) begin
      out_on_r   <= s1_on_r;
      out_chan_r <= map_rdata[mnr_pkg::ENTRY_W-1:mnr_pkg::NOTE_W];
      out_key_r  <= map_rdata[mnr_pkg::NOTE_W-1:0];
      out_vel_r  <= s1_vel_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_vel_r, out_key_r, out_chan_r};
  assign out_tuser  = out_on_r;

endmodule

### src/mnr_ram.sv
// generic single-write, single-read ram with registered read data
module mnr_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/mnr_window.sv
// three-byte receive window and note message detection
module mnr_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         byte_en,
  input  logic [mnr_pkg::BYTE_W-1:0]   rx_byte,
  output mnr_pkg::lookup_t             lookup
);

  logic [mnr_pkg::BYTE_W-1:0] w0_r, w0_nxt;
  logic [mnr_pkg::BYTE_W-1:0] w1_r, w1_nxt;
  logic [1:0]                 fill_r, fill_nxt;
  logic                       full;
  logic                       is_status;

  assign full      = (fill_r == 2'd2);
  assign is_status = (w0_r == mnr_pkg::STATUS_NOTE_ON) || (w0_r == mnr_pkg::STATUS_NOTE_OFF);

  always_comb begin
    w0_nxt   = w0_r;
    w1_nxt   = w1_r;
    fill_nxt = fill_r;
    if (byte_en) begin
      if (!full) begin
        if (fill_r[0]) begin
          w1_nxt = rx_byte;
        end else begin
          w0_nxt = rx_byte;
        end
        fill_nxt = fill_r + 2'd1;
      end else if (is_status) begin
        fill_nxt = 2'd0;
      end else begin
        // not a note message: slide down by one
        w0_nxt = w1_r;
        w1_nxt = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r   <= '0;
      w1_r   <= '0;
      fill_r <= '0;
    end else begin
      w0_r   <= w0_nxt;
      w1_r   <= w1_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign lookup.req      = byte_en && full && is_status;
  assign lookup.is_on    = (w0_r == mnr_pkg::STATUS_NOTE_ON);
  assign lookup.note     = w1_r[mnr_pkg::NOTE_W-1:0];
  assign lookup.velocity = rx_byte[mnr_pkg::VEL_W-1:0];

endmodule

### src/mnr_checker.sv
// port-level checks for the midi note remapper, bound to the top level
module mnr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input back-pressure only while a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // pad bits of the result word stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:18] == 6'd0)
    else $error("result pad bits set");

endmodule

bind midi_note_remapper mnr_checker u_mnr_checker (.*);
